[rtl/pdgm_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and types for the pairwise distance / group minimum unit.
// No dependencies.
package pdgm_pkg;

	localparam int MAX_ATOMS_DEF  = 64;
	localparam int MAX_GROUPS_DEF = 16;
	localparam int COORD_BITS_DEF = 24;

	localparam int CMD_W   = 2;
	localparam int KIND_W  = 2;
	localparam int GRP_W   = 4;
	localparam int OTHER_W = 6;
	localparam int DIST_W  = 25;
	localparam int OUT_DW  = ((OTHER_W + DIST_W + 7) / 8) * 8;

	// one squared axis operand, the three-term sum and its root
	localparam int SQ_W   = 26;
	localparam int ACC_W  = 2 * SQ_W + 2;
	localparam int ROOT_W = ACC_W / 2;

	localparam logic [DIST_W-1:0] DIST_NONE = '1;
	localparam logic [DIST_W-1:0] DIST_SAT  = {{(DIST_W-1){1'b1}}, 1'b0};

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR = 2'd0,
		CMD_ADD   = 2'd1,
		CMD_QUERY = 2'd2
	} cmd_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_PAIR  = 2'd0,
		KIND_GROUP = 2'd1,
		KIND_OVF   = 2'd2
	} kind_t;

endpackage

[rtl/pdgm_sqsum.sv]
`timescale 1ns / 1ps
// Sum of three squares on one shared multiplier, one axis per cycle.
// Depends on pdgm_pkg.
module pdgm_sqsum (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [pdgm_pkg::SQ_W-1:0]  dx,
	input  logic [pdgm_pkg::SQ_W-1:0]  dy,
	input  logic [pdgm_pkg::SQ_W-1:0]  dz,
	output logic                       done,
	output logic [pdgm_pkg::ACC_W-1:0] sum
);
	import pdgm_pkg::*;

	logic [SQ_W-1:0]   a_q, b_q, c_q;
	logic [2*SQ_W-1:0] prod_q;
	logic [ACC_W-1:0]  acc_q;
	logic [1:0]        phase_q;
	logic              run_q;
	logic              done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			done_q  <= 1'b0;
			phase_q <= '0;
		end else begin
			done_q <= run_q && (phase_q == 2'd3);
			if (start) begin
				run_q   <= 1'b1;
				phase_q <= '0;
			end else if (run_q) begin
				phase_q <= phase_q + 2'd1;
				if (phase_q == 2'd3)
					run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= dx;
			b_q   <= dy;
			c_q   <= dz;
			acc_q <= '0;
		end else if (run_q) begin
			prod_q <= a_q * a_q;
			a_q    <= b_q;
			b_q    <= c_q;
			if (phase_q != 2'd0)
				acc_q <= acc_q + ACC_W'(prod_q);
		end
	end

	assign done = done_q;
	assign sum  = acc_q;

endmodule

[rtl/pdgm_isqrt.sv]
`timescale 1ns / 1ps
// Restoring integer square root, one result bit per cycle.
// Depends on pdgm_pkg.
module pdgm_isqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [pdgm_pkg::ACC_W-1:0]  rad,
	output logic                        done,
	output logic [pdgm_pkg::ROOT_W-1:0] root
);
	import pdgm_pkg::*;

	localparam int CNT_W = $clog2(ROOT_W + 1);

	logic [ACC_W-1:0]  rad_q;
	logic [ROOT_W+1:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              run_q;
	logic              done_q;
	logic [ROOT_W+1:0] rem_nx;
	logic [ROOT_W+1:0] trial;

	always_comb begin
		rem_nx = {rem_q[ROOT_W-1:0], rad_q[ACC_W-1:ACC_W-2]};
		trial  = {root_q, 2'b01};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == CNT_W'(ROOT_W - 1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(ROOT_W - 1))
					run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			rad_q <= rad_q << 2;
			if (rem_nx >= trial) begin
				rem_q  <= rem_nx - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_nx;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

[rtl/pairwise_distance_group_min_unit.sv]
`timescale 1ns / 1ps
// Top level: atom store, group minimum table, sequencer and output register.
// Depends on pdgm_pkg, pdgm_sqsum, pdgm_isqrt.
//
//  port group | dir | tdata                                   | tuser | tlast
//  s_*        | in  | coord_x, coord_y, coord_z, group_id,    | cmd   | -
//             |     | group_a, group_b                        |       |
//  m_*        | out | other_atom, distance                    | kind  | last
//
// Add with n stored atoms: after the accept, each earlier atom takes a pass through
// read, difference, calc, table update and emit, bound by the 27-step square root
// unit after the shared multiply-accumulate. Clear and reset: a sweep of all
// MAX_GROUPS^2 table entries, s_tready low meanwhile.
// m_tready low holds the next result until the output register frees.
module pairwise_distance_group_min_unit #(
	parameter int MAX_ATOMS  = pdgm_pkg::MAX_ATOMS_DEF,
	parameter int MAX_GROUPS = pdgm_pkg::MAX_GROUPS_DEF,
	parameter int COORD_BITS = pdgm_pkg::COORD_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// coord_x, coord_y, coord_z, group_id, group_a, group_b, zero pad
	input  logic [((3*COORD_BITS+3*pdgm_pkg::GRP_W+7)/8)*8-1:0] s_tdata,
	// cmd
	input  logic [pdgm_pkg::CMD_W-1:0]      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// other_atom, distance, zero pad
	output logic [pdgm_pkg::OUT_DW-1:0]     m_tdata,
	// kind
	output logic [pdgm_pkg::KIND_W-1:0]     m_tuser,
	output logic                            m_tlast
);
	import pdgm_pkg::*;

	localparam int AW     = $clog2(MAX_ATOMS);
	localparam int CW     = AW + 1;
	localparam int TN     = MAX_GROUPS * MAX_GROUPS;
	localparam int TAW    = (TN > 1) ? $clog2(TN) : 1;
	localparam int DIFF_W = COORD_BITS + 1;
	localparam int WORD_W = 3 * COORD_BITS + GRP_W;

	typedef enum logic [8:0] {
		ST_CLR  = 9'b000000001,
		ST_IDLE = 9'b000000010,
		ST_RD   = 9'b000000100,
		ST_DIFF = 9'b000001000,
		ST_CALC = 9'b000010000,
		ST_TUPD = 9'b000100000,
		ST_QRD  = 9'b001000000,
		ST_EMIT = 9'b010000000,
		ST_HOLD = 9'b100000000
	} state_t;

	state_t state_q;

	logic [WORD_W-1:0] atom_mem [MAX_ATOMS];
	logic [WORD_W-1:0] atom_rd_q;
	logic [DIST_W-1:0] tbl_mem [TN];
	logic [DIST_W-1:0] tbl_rd_q;

	logic [CW-1:0]         count_q, n_q;
	logic [AW-1:0]         j_q;
	logic [TAW-1:0]        clr_q, tidx_q;
	logic [COORD_BITS-1:0] nx_q [3];
	logic [GRP_W-1:0]      ng_q;
	logic                  sat_q, upd_q, from_tbl_q;
	kind_t                 res_kind_q;
	logic [OTHER_W-1:0]    res_other_q;
	logic [DIST_W-1:0]     res_dist_q;
	logic                  res_last_q;

	logic                  m_valid_q;
	logic [KIND_W-1:0]     m_kind_q;
	logic [OTHER_W-1:0]    m_other_q;
	logic [DIST_W-1:0]     m_dist_q;
	logic                  m_last_q;

	logic [COORD_BITS-1:0] in_c [3];
	logic [GRP_W-1:0]      in_g, in_qa, in_qb, st_g, lo_g, hi_g, qlo, qhi;
	logic [COORD_BITS-1:0] st_c [3];
	logic [DIFF_W-1:0]     dif [3];
	logic [DIFF_W-1:0]     mag [3];
	logic [SQ_W-1:0]       opnd [3];
	logic                  sat_any;
	logic                  accept;
	logic                  out_free;
	logic [DIST_W-1:0]     emit_dist;

	logic                  tbl_we;
	logic [TAW-1:0]        tbl_wa;
	logic [DIST_W-1:0]     tbl_wd;

	logic                  sq_done, rt_done;
	logic [ACC_W-1:0]      sq_sum;
	logic [ROOT_W-1:0]     rt_root;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			in_c[i] = s_tdata[i*COORD_BITS +: COORD_BITS];
			st_c[i] = atom_rd_q[i*COORD_BITS +: COORD_BITS];
			dif[i]  = {nx_q[i][COORD_BITS-1], nx_q[i]} - {st_c[i][COORD_BITS-1], st_c[i]};
			mag[i]  = dif[i][DIFF_W-1] ? (~dif[i] + 1'b1) : dif[i];
			opnd[i] = SQ_W'(mag[i]);
		end
		sat_any = (64'(mag[0]) >= (64'd1 << SQ_W)) || (64'(mag[1]) >= (64'd1 << SQ_W)) ||
			(64'(mag[2]) >= (64'd1 << SQ_W));
		in_g  = s_tdata[3*COORD_BITS +: GRP_W];
		in_qa = s_tdata[3*COORD_BITS+GRP_W +: GRP_W];
		in_qb = s_tdata[3*COORD_BITS+2*GRP_W +: GRP_W];
		st_g  = atom_rd_q[3*COORD_BITS +: GRP_W];
		lo_g  = (ng_q < st_g) ? ng_q : st_g;
		hi_g  = (ng_q < st_g) ? st_g : ng_q;
		qlo   = (in_qa < in_qb) ? in_qa : in_qb;
		qhi   = (in_qa < in_qb) ? in_qb : in_qa;
	end

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign out_free  = !m_valid_q || m_tready;
	assign emit_dist = from_tbl_q ? tbl_rd_q : res_dist_q;

	always_comb begin
		tbl_we = 1'b0;
		tbl_wa = clr_q;
		tbl_wd = DIST_NONE;
		case (state_q)
			ST_CLR: begin
				tbl_we = 1'b1;
			end
			ST_TUPD: begin
				tbl_we = upd_q && (res_dist_q < tbl_rd_q);
				tbl_wa = tidx_q;
				tbl_wd = res_dist_q;
			end
			default: begin
				tbl_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (tbl_we)
			tbl_mem[tbl_wa] <= tbl_wd;
		tbl_rd_q <= tbl_mem[tidx_q];
		if (accept && s_tuser == CMD_ADD && count_q != CW'(MAX_ATOMS))
			atom_mem[count_q[AW-1:0]] <= s_tdata[WORD_W-1:0];
		if (state_q == ST_RD)
			atom_rd_q <= atom_mem[j_q];
	end

	pdgm_sqsum u_sqsum (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_DIFF),
		.dx     (opnd[0]),
		.dy     (opnd[1]),
		.dz     (opnd[2]),
		.done   (sq_done),
		.sum    (sq_sum)
	);

	pdgm_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_done),
		.rad    (sq_sum),
		.done   (rt_done),
		.root   (rt_root)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			clr_q     <= '0;
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (m_valid_q && m_tready && !(state_q == ST_EMIT && out_free))
				m_valid_q <= 1'b0;
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == TAW'(TN - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) begin
						case (s_tuser)
							CMD_CLEAR: begin
								count_q <= '0;
								clr_q   <= '0;
								state_q <= ST_CLR;
							end
							CMD_ADD: begin
								if (count_q == CW'(MAX_ATOMS)) begin
									state_q <= ST_EMIT;
								end else begin
									count_q <= count_q + 1'b1;
									if (count_q != '0)
										state_q <= ST_RD;
								end
							end
							CMD_QUERY: begin
								if (32'(in_qa) < MAX_GROUPS && 32'(in_qb) < MAX_GROUPS &&
									in_qa != in_qb)
									state_q <= ST_QRD;
								else
									state_q <= ST_EMIT;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_RD: begin
					state_q <= ST_DIFF;
				end
				ST_DIFF: begin
					state_q <= ST_CALC;
				end
				ST_CALC: begin
					if (rt_done)
						state_q <= ST_TUPD;
				end
				ST_TUPD: begin
					state_q <= ST_EMIT;
				end
				ST_QRD: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						if (res_kind_q == KIND_PAIR && !res_last_q)
							state_q <= ST_RD;
						else
							state_q <= ST_IDLE;
					end
				end
				ST_HOLD: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				res_other_q <= '0;
				res_last_q  <= 1'b1;
				j_q         <= '0;
				n_q         <= count_q;
				ng_q        <= in_g;
				for (int i = 0; i < 3; i++)
					nx_q[i] <= in_c[i];
				if (s_tuser == CMD_QUERY) begin
					res_kind_q <= KIND_GROUP;
					tidx_q     <= TAW'(32'(qlo) * MAX_GROUPS + 32'(qhi));
					from_tbl_q <= (32'(in_qa) < MAX_GROUPS && 32'(in_qb) < MAX_GROUPS &&
						in_qa != in_qb);
					if (32'(in_qa) >= MAX_GROUPS || 32'(in_qb) >= MAX_GROUPS)
						res_dist_q <= DIST_NONE;
					else
						res_dist_q <= '0;
				end else begin
					from_tbl_q <= 1'b0;
					res_kind_q <= KIND_OVF;
					res_dist_q <= '0;
				end
			end
			ST_DIFF: begin
				res_kind_q  <= KIND_PAIR;
				res_other_q <= OTHER_W'(j_q);
				res_last_q  <= (CW'(j_q) + 1'b1 == n_q);
				sat_q       <= sat_any;
				upd_q       <= (32'(ng_q) < MAX_GROUPS) && (32'(st_g) < MAX_GROUPS) &&
					(ng_q != st_g);
				tidx_q      <= TAW'(32'(lo_g) * MAX_GROUPS + 32'(hi_g));
			end
			ST_CALC: begin
				if (sat_q || rt_root > ROOT_W'(DIST_SAT))
					res_dist_q <= DIST_SAT;
				else
					res_dist_q <= DIST_W'(rt_root);
			end
			ST_EMIT: begin
				if (out_free) begin
					m_kind_q  <= res_kind_q;
					m_other_q <= res_other_q;
					m_dist_q  <= emit_dist;
					m_last_q  <= res_last_q;
					j_q       <= j_q + 1'b1;
				end
			end
			default: begin
				j_q <= j_q;
			end
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = OUT_DW'({m_dist_q, m_other_q});
	assign m_tuser  = m_kind_q;
	assign m_tlast  = m_last_q;

endmodule
